>>> design/u8le_pkg.sv
// Shared types and constants for the UTF-8 line encoder.
package u8le_pkg;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = 3;

  localparam logic [31:0] MaxCodePoint  = 32'h0010_FFFF;
  localparam logic [31:0] NoncharLow    = 32'h0000_FFFE;
  localparam logic [31:0] NoncharHigh   = 32'h0000_FFFF;
  localparam logic [31:0] Limit1Byte    = 32'h0000_007F;
  localparam logic [31:0] Limit2Byte    = 32'h0000_07FF;
  localparam logic [31:0] Limit3Byte    = 32'h0000_FFFF;
  localparam logic [20:0] ReplacementCp = 21'h00_FFFD;

  localparam logic [7:0] Lead2Byte   = 8'hC0;
  localparam logic [7:0] Lead3Byte   = 8'hE0;
  localparam logic [7:0] Lead4Byte   = 8'hF0;
  localparam logic [7:0] ContByte    = 8'h80;
  localparam logic [7:0] NewlineByte = 8'h0A;

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // Result of the classify stage.
  typedef struct packed {
    logic [20:0]     cp;
    logic [CntW-1:0] n_chr;
    logic            line_end;
  } cls_t;

  // Result of the pack stage: bytes in emission order and their count.
  typedef struct packed {
    byte_vec_t       bytes;
    logic [CntW-1:0] count;
  } pack_t;

endpackage

>>> design/u8le_if.sv
// Valid/ready channel interfaces for code points in and bytes out.
interface u8le_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic        has_char;
  logic        line_end;

  modport source (output valid, code_point, has_char, line_end, input ready);
  modport sink (input valid, code_point, has_char, line_end, output ready);
  modport monitor (input valid, ready, code_point, has_char, line_end);
endinterface

interface u8le_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
  modport monitor (input valid, ready, out_byte, last_byte);
endinterface

>>> design/utf8_line_encoder_unit.sv
// Top level of the UTF-8 line encoder.
//
// in_ch carries one code point per transaction, with has_char (encode the
// code point) and line_end (append a newline byte 0x0A). out_ch carries one
// byte per transaction; last_byte marks the final byte of each input item.
// Noncharacters U+FFFE, U+FFFF and values above 0x10FFFF come out as U+FFFD.
// An item with neither flag set produces no bytes.
//
// The path has three register stages: classify, pack and a serializer.
// The first byte of an item is valid on out_ch once the item has passed the
// classify and pack registers and been loaded into the serializer.
// The serializer sends one byte per cycle while out_ch.ready is high; an
// item has one to five bytes, the next item can load as the last byte is
// taken, and an empty item is dropped as it loads. While the serializer
// works, the two earlier stages keep taking items until they are full.
// Synchronous reset empties all stages; no bytes are valid after it.
// When out_ch stalls, the current byte holds and the stages fill up in
// turn, after which in_ch.ready drops; nothing is lost or repeated.
module utf8_line_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  u8le_in_if.sink    in_ch,
  u8le_out_if.source out_ch
);

  logic            cls_valid, cls_ready;
  u8le_pkg::cls_t  cls;
  logic            pk_valid, pk_ready;
  u8le_pkg::pack_t pk;

  u8le_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_ready (cls_ready)
  );

  u8le_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_ready (cls_ready),
    .pk_valid  (pk_valid),
    .pk        (pk),
    .pk_ready  (pk_ready)
  );

  u8le_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .pk_valid (pk_valid),
    .pk       (pk),
    .pk_ready (pk_ready),
    .out_ch   (out_ch)
  );

endmodule

>>> design/u8le_classify.sv
// First stage: replaces invalid code points and sizes the encoding.
module u8le_classify (
  input  logic                clk,
  input  logic                rst_n,
  u8le_in_if.sink             in_ch,
  output logic                cls_valid,
  output u8le_pkg::cls_t      cls,
  input  logic                cls_ready
);

  logic           valid_r, valid_nxt;
  u8le_pkg::cls_t data_r, data_nxt;
  logic           take;
  logic           bad_cp;

  assign in_ch.ready = !valid_r || cls_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    bad_cp = (in_ch.code_point == u8le_pkg::NoncharLow) ||
             (in_ch.code_point == u8le_pkg::NoncharHigh) ||
             (in_ch.code_point > u8le_pkg::MaxCodePoint);
    data_nxt          = data_r;
    data_nxt.line_end = in_ch.line_end;
    data_nxt.cp       = bad_cp ? u8le_pkg::ReplacementCp : in_ch.code_point[20:0];
    if (!in_ch.has_char) begin
      data_nxt.n_chr = u8le_pkg::CntW'(0);
    end else if (bad_cp) begin
      data_nxt.n_chr = u8le_pkg::CntW'(3);
    end else if (in_ch.code_point <= u8le_pkg::Limit1Byte) begin
      data_nxt.n_chr = u8le_pkg::CntW'(1);
    end else if (in_ch.code_point <= u8le_pkg::Limit2Byte) begin
      data_nxt.n_chr = u8le_pkg::CntW'(2);
    end else if (in_ch.code_point <= u8le_pkg::Limit3Byte) begin
      data_nxt.n_chr = u8le_pkg::CntW'(3);
    end else begin
      data_nxt.n_chr = u8le_pkg::CntW'(4);
    end
    if (take) begin
      valid_nxt = 1'b1;
    end else if (cls_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls       = data_r;

endmodule

>>> design/u8le_pack.sv
// Second stage: builds the byte sequence of one transaction.
module u8le_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cls_valid,
  input  u8le_pkg::cls_t      cls,
  output logic                cls_ready,
  output logic                pk_valid,
  output u8le_pkg::pack_t     pk,
  input  logic                pk_ready
);

  logic            valid_r, valid_nxt;
  u8le_pkg::pack_t data_r, data_nxt;
  logic            take;

  assign cls_ready = !valid_r || pk_ready;
  assign take      = cls_valid && cls_ready;

  always_comb begin
    data_nxt.bytes = '0;
    case (cls.n_chr)
      u8le_pkg::CntW'(1): begin
        data_nxt.bytes[0] = {1'b0, cls.cp[6:0]};
      end
      u8le_pkg::CntW'(2): begin
        data_nxt.bytes[0] = u8le_pkg::Lead2Byte | {3'b000, cls.cp[10:6]};
        data_nxt.bytes[1] = u8le_pkg::ContByte | {2'b00, cls.cp[5:0]};
      end
      u8le_pkg::CntW'(3): begin
        data_nxt.bytes[0] = u8le_pkg::Lead3Byte | {4'b0000, cls.cp[15:12]};
        data_nxt.bytes[1] = u8le_pkg::ContByte | {2'b00, cls.cp[11:6]};
        data_nxt.bytes[2] = u8le_pkg::ContByte | {2'b00, cls.cp[5:0]};
      end
      u8le_pkg::CntW'(4): begin
        data_nxt.bytes[0] = u8le_pkg::Lead4Byte | {5'b00000, cls.cp[20:18]};
        data_nxt.bytes[1] = u8le_pkg::ContByte | {2'b00, cls.cp[17:12]};
        data_nxt.bytes[2] = u8le_pkg::ContByte | {2'b00, cls.cp[11:6]};
        data_nxt.bytes[3] = u8le_pkg::ContByte | {2'b00, cls.cp[5:0]};
      end
      default: begin
        data_nxt.bytes = '0;
      end
    endcase
    // The newline goes right after the character bytes.
    for (int i = 0; i < u8le_pkg::MaxBytes; i++) begin
      if (cls.line_end && (cls.n_chr == u8le_pkg::CntW'(i))) begin
        data_nxt.bytes[i] = u8le_pkg::NewlineByte;
      end
    end
    data_nxt.count = cls.n_chr + u8le_pkg::CntW'(cls.line_end);
    if (take) begin
      valid_nxt = 1'b1;
    end else if (pk_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign pk_valid = valid_r;
  assign pk       = data_r;

endmodule

>>> design/u8le_serial.sv
// Third stage: holds one byte sequence and sends it out one byte per cycle while out_ch is ready.
module u8le_serial (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pk_valid,
  input  u8le_pkg::pack_t           pk,
  output logic                      pk_ready,
  u8le_out_if.source                out_ch
);

  logic                      busy_r, busy_nxt;
  u8le_pkg::byte_vec_t       bytes_r;
  logic [u8le_pkg::CntW-1:0] count_r;
  logic [u8le_pkg::CntW-1:0] idx_r, idx_nxt;
  logic                      at_last;
  logic                      done;
  logic                      take;

  assign at_last  = (idx_r == count_r - u8le_pkg::CntW'(1));
  assign done     = out_ch.valid && out_ch.ready && at_last;
  assign pk_ready = !busy_r || done;
  assign take     = pk_valid && pk_ready;

  assign out_ch.valid     = busy_r;
  assign out_ch.out_byte  = bytes_r[idx_r];
  assign out_ch.last_byte = at_last;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (take) begin
      // A transaction that yields no byte is dropped here.
      busy_nxt = (pk.count != '0);
      idx_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      idx_nxt = idx_r + u8le_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bytes_r <= pk.bytes;
      count_r <= pk.count;
    end
  end

endmodule

>>> design/u8le_checker.sv
// Port-level assertions for the UTF-8 line encoder, bound to the top level.
module u8le_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Reset leaves no byte pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled byte stays as it is.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed under stall");

  // A lead byte is always followed by continuation bytes of the same item.
  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte[7:6] == 2'b11) |-> !out_last)
    else $error("lead byte marked as last");

  // Bytes F5..FF never appear in a sequence for U+10FFFF or below.
  a_no_high_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte <= 8'hF4))
    else $error("illegal byte value");

endmodule

bind utf8_line_encoder_unit u8le_checker u_u8le_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_byte)
);
